### hw/rtl/qfv_pkg.sv
// ----------------------------------------------------------------------------
// qfv_pkg: shared types and constants of the quadratic form variance block
// Holds the matrix sizes, datapath widths, opcodes, sequencer states and the
// structs that connect the sequencer to the matrix store.
// ----------------------------------------------------------------------------
`default_nettype none

package qfv_pkg;

  // Matrix geometry.
  localparam int MAX_DIM    = 4;
  localparam int NUM_BLOCKS = 4;
  localparam int D2         = MAX_DIM * MAX_DIM;
  localparam int D4         = D2 * D2;

  // Widths fixed by the beat fields.
  localparam int DATA_W  = 16;
  localparam int FUNC_W  = 2;
  localparam int BLK_W   = 2;
  localparam int POS_W   = 2;
  localparam int DIM_W   = 3;
  localparam int OUT_W   = 48;
  localparam int FRAC_SH = 24;

  localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;

  // Index and address widths.
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int COV_AW = (D2 > 1) ? $clog2(D2) : 1;
  localparam int W_AW   = (NUM_BLOCKS * D2 > 1) ? $clog2(NUM_BLOCKS * D2) : 1;

  // Datapath widths. A single element product fits in PROD_W bits, a sum of
  // three such products in SS_W bits, the trace in TR_W bits and the whole
  // exact sum in ACC_W bits.
  localparam int PROD_W = 2 * DATA_W;
  localparam int SS_W   = PROD_W + 1;
  localparam int MUL_W  = SS_W;
  localparam int MULP_W = 2 * MUL_W;
  localparam int TR_W   = PROD_W + ((D2 > 1) ? $clog2(D2) : 0);
  localparam int LO_W   = TR_W / 2;
  localparam int HI_W   = TR_W - LO_W;
  localparam int ACC_W  = 4 * DATA_W + ((D4 > 1) ? $clog2(D4) : 0);

  // Operation carried in the input tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_COV = 2'd0,
    FUNC_LOAD_W   = 2'd1,
    FUNC_COMPUTE  = 2'd2
  } func_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_TERM,
    ST_DRAIN,
    ST_TRACE,
    ST_TR_DRAIN,
    ST_SQUARE,
    ST_SAT
  } state_e;

  // Write request into the matrix store.
  typedef struct packed {
    logic                     cov_we;
    logic                     w_we;
    logic [COV_AW-1:0]        cov_addr;
    logic [W_AW-1:0]          w_addr;
    logic signed [DATA_W-1:0] data;
  } qfv_wr_t;

  // Read addresses for the two ports of each matrix.
  typedef struct packed {
    logic [COV_AW-1:0] cov_a;
    logic [COV_AW-1:0] cov_b;
    logic [W_AW-1:0]   w_a;
    logic [W_AW-1:0]   w_b;
  } qfv_rd_t;

endpackage

`default_nettype wire

### hw/rtl/qfv_store.sv
// ----------------------------------------------------------------------------
// qfv_store: covariance and weight matrix memories
// One write port shared by both matrices and two registered read ports on
// each, addressed by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module qfv_store
  import qfv_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire qfv_wr_t                  wr_i,
  input  wire qfv_rd_t                  rd_i,
  output logic signed [DATA_W-1:0]      cov_a_o,
  output logic signed [DATA_W-1:0]      cov_b_o,
  output logic signed [DATA_W-1:0]      w_a_o,
  output logic signed [DATA_W-1:0]      w_b_o
);

  logic signed [DATA_W-1:0] cov_mem [D2];
  logic signed [DATA_W-1:0] w_mem   [NUM_BLOCKS * D2];

  // Covariance matrix, row-major.
  always_ff @(posedge clk_i) begin
    if (wr_i.cov_we) begin
      cov_mem[wr_i.cov_addr] <= wr_i.data;
    end
    cov_a_o <= cov_mem[rd_i.cov_a];
    cov_b_o <= cov_mem[rd_i.cov_b];
  end

  // Weight blocks, one after another, each row-major.
  always_ff @(posedge clk_i) begin
    if (wr_i.w_we) begin
      w_mem[wr_i.w_addr] <= wr_i.data;
    end
    w_a_o <= w_mem[rd_i.w_a];
    w_b_o <= w_mem[rd_i.w_b];
  end

endmodule

`default_nettype wire

### hw/rtl/quadratic_form_variance.sv
// ----------------------------------------------------------------------------
// quadratic_form_variance: variance of a Gaussian quadratic form per block
// Loads a covariance matrix and weight blocks element by element and, on a
// compute beat, returns the exact fourth-order sum minus the squared trace,
// shifted to Q.24 and saturated to 48 bits.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: func; tdata: block, row, col, element (Q3.12)
//  m_axis    out        tuser: result block; tdata: variance (Q23.24)
//  cfg       in         dim_in_use, written whenever cfg_we_i is high
//
//  A load beat gives no result beat.
//  A compute beat is worked through term by term before its result is
//  offered; every product goes through the one 33x33 multiplier,
//  five of them for each of the d^4 terms.
//  Input tready is low from the compute beat until its result is registered.
//  The result waits in an output register, so loads are taken while it stalls.
//  Reset clears control state and sets dim_in_use to 4; matrices hold garbage.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_form_variance
  import qfv_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration.
  input  wire logic               cfg_we_i,
  input  wire logic [DIM_W-1:0]   cfg_wdata_i,    // dim_in_use
  // Input stream.
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [23:0]        s_axis_tdata,   // block[1:0], row[3:2],
                                                  // col[5:4], element[21:6]
  input  wire logic [FUNC_W-1:0]  s_axis_tuser,   // func[1:0]
  // Result stream.
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [OUT_W-1:0]        m_axis_tdata,   // variance_value[47:0]
  output logic [BLK_W-1:0]        m_axis_tuser    // result_block[1:0]
);

  // Micro-steps of one fourth-order term.
  localparam logic [2:0] STEP_ISSUE = 3'd0;
  localparam logic [2:0] STEP_A     = 3'd1;
  localparam logic [2:0] STEP_B     = 3'd2;
  localparam logic [2:0] STEP_C     = 3'd3;
  localparam logic [2:0] STEP_WW    = 3'd4;
  localparam logic [2:0] STEP_W     = 3'd5;

  // Address helpers.
  function automatic logic [COV_AW-1:0] cov_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    cov_addr = COV_AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  function automatic logic [W_AW-1:0] w_addr(input logic [BLK_W-1:0] b,
                                             input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
    w_addr = W_AW'(int'(b) * D2 + int'(r) * MAX_DIM + int'(c));
  endfunction

  // --------------------------------------------------------------------------
  // Declarations.
  // --------------------------------------------------------------------------
  state_e                    state_q, state_d;
  logic [2:0]                step_q, step_d;
  logic [IDX_W-1:0]          i_q, j_q, k_q, s_q;
  logic [IDX_W-1:0]          i_d, j_d, k_d, s_d;
  logic [DIM_W-1:0]          dim_q;
  logic [DIM_W-1:0]          d_q, d_d;
  logic [BLK_W-1:0]          blk_q, blk_d;
  logic                      pend_q, pend_d;
  logic                      trpend_q, trpend_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [SS_W-1:0]    ss_q, ss_d;
  logic signed [TR_W-1:0]    tr_q, tr_d;
  logic signed [MULP_W-1:0]  prod_q, prod_d;
  logic [OUT_W-1:0]          out_data_q, out_data_d;
  logic [BLK_W-1:0]          out_blk_q, out_blk_d;
  logic                      out_valid_q, out_valid_d;

  logic                      s_fire;
  func_e                     s_func;
  logic [BLK_W-1:0]          s_blk;
  logic [POS_W-1:0]          s_row, s_col;
  logic signed [DATA_W-1:0]  s_elem;
  logic                      pos_ok, blk_ok;
  logic [DIM_W-1:0]          d_eff;

  logic                      i_last, j_last, k_last, s_last, term_last;
  logic [IDX_W-1:0]          i_nx, j_nx, k_nx, s_nx;
  logic [IDX_W-1:0]          ri, rj, rk, rs;

  qfv_wr_t                   wr;
  qfv_rd_t                   rd;
  logic signed [DATA_W-1:0]  cov_a_rd, cov_b_rd, w_a_rd, w_b_rd;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [MULP_W-1:0]  mul_p;
  logic signed [MUL_W-1:0]   tr_hi, tr_lo;

  logic [ACC_W-FRAC_SH-OUT_W:0] sat_top;
  logic                      sat_fits;
  logic [OUT_W-1:0]          sat_val;
  logic                      out_free;

  // --------------------------------------------------------------------------
  // Beat unpacking and range checks.
  // --------------------------------------------------------------------------
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign s_func = func_e'(s_axis_tuser);
  assign s_blk  = s_axis_tdata[1:0];
  assign s_row  = s_axis_tdata[3:2];
  assign s_col  = s_axis_tdata[5:4];
  assign s_elem = $signed(s_axis_tdata[21:6]);

  assign pos_ok = (int'(s_row) < MAX_DIM) && (int'(s_col) < MAX_DIM);
  assign blk_ok = int'(s_blk) < NUM_BLOCKS;

  // Side length in use, clamped to the supported range.
  always_comb begin
    if (dim_q == '0) begin
      d_eff = DIM_W'(1);
    end else if (int'(dim_q) > MAX_DIM) begin
      d_eff = DIM_W'(MAX_DIM);
    end else begin
      d_eff = dim_q;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      dim_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Loop counters: i, j, k, s for the terms; i, j again for the trace.
  // --------------------------------------------------------------------------
  assign i_last    = DIM_W'(i_q) == d_q - DIM_W'(1);
  assign j_last    = DIM_W'(j_q) == d_q - DIM_W'(1);
  assign k_last    = DIM_W'(k_q) == d_q - DIM_W'(1);
  assign s_last    = DIM_W'(s_q) == d_q - DIM_W'(1);
  assign term_last = i_last && j_last && k_last && s_last;

  always_comb begin
    s_nx = s_last ? '0 : s_q + IDX_W'(1);
    k_nx = k_q;
    j_nx = j_q;
    i_nx = i_q;
    if (s_last) begin
      k_nx = k_last ? '0 : k_q + IDX_W'(1);
      if (k_last) begin
        j_nx = j_last ? '0 : j_q + IDX_W'(1);
        if (j_last) begin
          i_nx = i_q + IDX_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Matrix store and its requests.
  // --------------------------------------------------------------------------
  always_comb begin
    wr          = '0;
    wr.cov_addr = cov_addr(IDX_W'(s_row), IDX_W'(s_col));
    wr.w_addr   = w_addr(s_blk, IDX_W'(s_row), IDX_W'(s_col));
    wr.data     = s_elem;
    if (s_fire && pos_ok) begin
      wr.cov_we = (s_func == FUNC_LOAD_COV);
      wr.w_we   = (s_func == FUNC_LOAD_W) && blk_ok;
    end
  end

  // On the last step of a term the next term's first reads are issued.
  always_comb begin
    if (state_q == ST_TERM && step_q == STEP_W) begin
      ri = i_nx;
      rj = j_nx;
      rk = k_nx;
      rs = s_nx;
    end else begin
      ri = i_q;
      rj = j_q;
      rk = k_q;
      rs = s_q;
    end
  end

  always_comb begin
    rd.w_a   = w_addr(blk_q, ri, rj);
    rd.w_b   = w_addr(blk_q, rk, rs);
    rd.cov_a = cov_addr(ri, rj);
    rd.cov_b = cov_addr(rk, rs);
    if (state_q == ST_TRACE) begin
      rd.cov_a = cov_addr(j_q, i_q);
    end else if (state_q == ST_TERM && step_q == STEP_A) begin
      rd.cov_a = cov_addr(i_q, k_q);
      rd.cov_b = cov_addr(j_q, s_q);
    end else if (state_q == ST_TERM && step_q == STEP_B) begin
      rd.cov_a = cov_addr(i_q, s_q);
      rd.cov_b = cov_addr(j_q, k_q);
    end
  end

  qfv_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .cov_a_o (cov_a_rd),
    .cov_b_o (cov_b_rd),
    .w_a_o   (w_a_rd),
    .w_b_o   (w_b_rd)
  );

  // --------------------------------------------------------------------------
  // Shared multiplier with its operand selection.
  // --------------------------------------------------------------------------
  assign tr_hi = MUL_W'($signed(tr_q[TR_W-1:LO_W]));
  assign tr_lo = MUL_W'(tr_q[LO_W-1:0]);

  always_comb begin
    mul_a = MUL_W'(cov_a_rd);
    mul_b = MUL_W'(cov_b_rd);
    unique case (state_q)
      ST_TERM: begin
        if (step_q == STEP_WW) begin
          mul_a = MUL_W'(w_a_rd);
          mul_b = MUL_W'(w_b_rd);
        end else if (step_q == STEP_W) begin
          mul_a = MUL_W'(prod_q);
          mul_b = ss_q;
        end
      end
      ST_TRACE: begin
        mul_a = MUL_W'(w_a_rd);
        mul_b = MUL_W'(cov_a_rd);
      end
      ST_SQUARE: begin
        mul_a = (step_q == STEP_B) ? tr_lo : tr_hi;
        mul_b = (step_q == STEP_ISSUE) ? tr_hi : tr_lo;
      end
      default: begin
        mul_a = MUL_W'(cov_a_rd);
        mul_b = MUL_W'(cov_b_rd);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // --------------------------------------------------------------------------
  // Shift to Q.24 and saturate to the output width.
  // --------------------------------------------------------------------------
  assign sat_top  = acc_q[ACC_W-1:FRAC_SH+OUT_W-1];
  assign sat_fits = (&sat_top) || !(|sat_top);

  always_comb begin
    if (sat_fits) begin
      sat_val = acc_q[FRAC_SH+OUT_W-1:FRAC_SH];
    end else if (acc_q[ACC_W-1]) begin
      sat_val = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  // --------------------------------------------------------------------------
  // Sequencer: next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && s_func == FUNC_COMPUTE && blk_ok) begin
          state_d = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_d = ST_TERM;
      end
      ST_TERM: begin
        if (step_q == STEP_W && term_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_TRACE;
      end
      ST_TRACE: begin
        if (step_q == STEP_A && i_last && j_last) begin
          state_d = ST_TR_DRAIN;
        end
      end
      ST_TR_DRAIN: begin
        state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (step_q == STEP_C) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: datapath and counter updates.
  // --------------------------------------------------------------------------
  always_comb begin
    step_d      = step_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    s_d         = s_q;
    d_d         = d_q;
    blk_d       = blk_q;
    pend_d      = pend_q;
    trpend_d    = trpend_q;
    acc_d       = acc_q;
    ss_d        = ss_q;
    tr_d        = tr_q;
    prod_d      = prod_q;
    out_data_d  = out_data_q;
    out_blk_d   = out_blk_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && s_func == FUNC_COMPUTE && blk_ok) begin
          i_d      = '0;
          j_d      = '0;
          k_d      = '0;
          s_d      = '0;
          d_d      = d_eff;
          blk_d    = s_blk;
          pend_d   = 1'b0;
          trpend_d = 1'b0;
          acc_d    = '0;
          tr_d     = '0;
        end
      end
      ST_PRIME: begin
        step_d = STEP_A;
      end
      ST_TERM: begin
        step_d = step_q + 3'd1;
        prod_d = mul_p;
        case (step_q)
          STEP_A: begin
            // Fold in the previous term's product.
            if (pend_q) begin
              acc_d = acc_q + ACC_W'(prod_q);
            end
            pend_d = 1'b0;
          end
          STEP_B: begin
            ss_d = SS_W'(prod_q);
          end
          STEP_C, STEP_WW: begin
            ss_d = ss_q + SS_W'(prod_q);
          end
          default: begin
            // Weight product times covariance sum; move to the next term.
            pend_d = 1'b1;
            if (term_last) begin
              step_d = STEP_ISSUE;
              i_d    = '0;
              j_d    = '0;
              k_d    = '0;
              s_d    = '0;
            end else begin
              step_d = STEP_A;
              i_d    = i_nx;
              j_d    = j_nx;
              k_d    = k_nx;
              s_d    = s_nx;
            end
          end
        endcase
      end
      ST_DRAIN: begin
        acc_d    = acc_q + ACC_W'(prod_q);
        pend_d   = 1'b0;
        trpend_d = 1'b0;
        step_d   = STEP_ISSUE;
      end
      ST_TRACE: begin
        if (step_q == STEP_ISSUE) begin
          if (trpend_q) begin
            tr_d = tr_q + TR_W'(prod_q);
          end
          step_d = STEP_A;
        end else begin
          prod_d   = mul_p;
          trpend_d = 1'b1;
          step_d   = STEP_ISSUE;
          j_d      = j_last ? '0 : j_q + IDX_W'(1);
          if (j_last) begin
            i_d = i_q + IDX_W'(1);
          end
        end
      end
      ST_TR_DRAIN: begin
        tr_d     = tr_q + TR_W'(prod_q);
        trpend_d = 1'b0;
        step_d   = STEP_ISSUE;
      end
      ST_SQUARE: begin
        // Trace squared as hi*hi, 2*hi*lo and lo*lo partial products.
        step_d = step_q + 3'd1;
        prod_d = mul_p;
        case (step_q)
          STEP_A:  acc_d = acc_q - (ACC_W'(prod_q) <<< (2 * LO_W));
          STEP_B:  acc_d = acc_q - (ACC_W'(prod_q) <<< (LO_W + 1));
          STEP_C:  acc_d = acc_q - ACC_W'(prod_q);
          default: acc_d = acc_q;
        endcase
      end
      ST_SAT: begin
        if (out_free) begin
          out_data_d  = sat_val;
          out_blk_d   = blk_q;
          out_valid_d = 1'b1;
          step_d      = STEP_ISSUE;
        end
      end
      default: begin
        step_d = STEP_ISSUE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_ISSUE;
      pend_q      <= 1'b0;
      trpend_q    <= 1'b0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      s_q         <= '0;
      d_q         <= DIM_RESET;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pend_q      <= pend_d;
      trpend_q    <= trpend_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      s_q         <= s_d;
      d_q         <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q      <= blk_d;
    acc_q      <= acc_d;
    ss_q       <= ss_d;
    tr_q       <= tr_d;
    prod_q     <= prod_d;
    out_data_q <= out_data_d;
    out_blk_q  <= out_blk_d;
  end

  // Ports.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_blk_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A valid compute beat starts the sequence on the next cycle.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_func == FUNC_COMPUTE && blk_ok) |=> (state_q == ST_PRIME))
    else $error("compute beat did not start the sequencer");

  // A new result beat only appears after the saturation step.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_SAT))
    else $error("result offered outside the saturation step");

  // Term counters stay inside the active side length, the micro-step in STEP_A..STEP_W.
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TERM) |-> (DIM_W'(i_q) < d_q && DIM_W'(j_q) < d_q &&
                              DIM_W'(k_q) < d_q && DIM_W'(s_q) < d_q &&
                              step_q >= STEP_A && step_q <= STEP_W))
    else $error("term counters out of range");

endmodule

`default_nettype wire
